// ----- rtl/tpt_pkg.sv -----
// Shared constants and sequencer state type for the TLB page table translator.
package tpt_pkg;

  localparam int unsigned TlbEntries = 16;
  localparam int unsigned TlbIdxW    = $clog2(TlbEntries);
  localparam int unsigned PageCount  = 256;
  localparam int unsigned PageW      = 8;
  localparam int unsigned FrameCount = 256;
  localparam int unsigned FrameW     = 8;
  localparam int unsigned FreeW      = 9;
  localparam int unsigned CountW     = 32;
  localparam int unsigned InDataW    = 16;
  localparam int unsigned OutDataW   = 128;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_RESOLVE,
    ST_SCAN,
    ST_EVICT,
    ST_FILL,
    ST_DONE
  } state_e;

endpackage

// ----- rtl/tlb_page_table_translator.sv -----
// Top level of the TLB page table translator: sequencer, TLB, page table and counters.
//
// The block translates one 16-bit logical address per input beat. The slave
// stream carries the address; the master stream returns one result beat per
// address with the physical address, hit, fault and eviction flags, and the
// running hit, fault and access totals.
// Timing: after a beat is accepted the block searches the 16-entry TLB in the
// lookup state while reading the page table memory, then resolves the access in
// the next. A TLB hit goes on to the done state, a TLB miss through the fill state
// first; a new beat is accepted only once the sequencer is back in idle.
// A fault with no free frame left scans the residence map one page per cycle
// for the lowest resident page, reads its frame, and then finishes.
// Input ready is high only while the sequencer is idle; it does not wait for
// the receiver, because a finished result sits in an output register. A new
// result is only written there once the previous beat has been taken, so a
// stalled receiver holds the block at the end of its next item.
// Reset clears the TLB valid bits, the residence map, the free-frame counter,
// the fill pointer and all totals. The page table frames need no clearing:
// a frame is only read for a resident page.
module tlb_page_table_translator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [15:0] virtual address
  input  logic [tpt_pkg::InDataW-1:0]   s_axis_tdata_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [15:0] phys_addr, [16] tlb_hit, [17] page_fault, [18] evicted_valid,
  // [26:19] evicted_page, [58:27] hit_total, [90:59] fault_total,
  // [122:91] access_total, [127:123] zero
  output logic [tpt_pkg::OutDataW-1:0]  m_axis_tdata_o
);

  localparam int unsigned TlbN   = tpt_pkg::TlbEntries;
  localparam int unsigned IdxW   = tpt_pkg::TlbIdxW;
  localparam int unsigned PgW    = tpt_pkg::PageW;
  localparam int unsigned FrW    = tpt_pkg::FrameW;
  localparam int unsigned CntW   = tpt_pkg::CountW;
  localparam int unsigned FreeW  = tpt_pkg::FreeW;

  tpt_pkg::state_e state_q, state_d;

  // TLB storage. Page and frame fields are only read behind a valid bit.
  logic [TlbN-1:0]          tlb_valid_q;
  logic [PgW-1:0]           tlb_page_q  [TlbN];
  logic [FrW-1:0]           tlb_frame_q [TlbN];
  logic [IdxW-1:0]          fill_ptr_q;

  // Residence map in flip-flops, frames in a memory with a registered read.
  logic [tpt_pkg::PageCount-1:0] resident_q;
  logic [FrW-1:0]           page_frame_mem [tpt_pkg::PageCount];
  logic [PgW-1:0]           pt_raddr;
  logic [FrW-1:0]           pt_rdata_q;

  logic [FreeW-1:0]         next_free_q;
  logic [CntW-1:0]          hit_cnt_q, fault_cnt_q, access_cnt_q;

  // Per-item working registers.
  logic [PgW-1:0]           page_q;
  logic [7:0]               offset_q;
  logic [FrW-1:0]           frame_q;
  logic                     hit_q, fault_q, ev_valid_q;
  logic [PgW-1:0]           ev_page_q;
  logic [PgW-1:0]           scan_q;

  logic                     out_valid_q;
  logic [tpt_pkg::OutDataW-1:0] out_data_q;

  logic                     in_fire;
  logic                     out_free;
  logic                     tlb_match;
  logic [FrW-1:0]           tlb_match_frame;
  logic                     free_avail;
  logic                     scan_hit;
  logic                     scan_last;
  logic [CntW-1:0]          hit_cnt_nxt, fault_cnt_nxt, access_cnt_nxt;

  assign in_fire    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free   = !out_valid_q || m_axis_tready_i;
  assign free_avail = next_free_q < FreeW'(tpt_pkg::FrameCount);
  assign scan_hit   = resident_q[scan_q];
  assign scan_last  = scan_q == PgW'(tpt_pkg::PageCount - 1);

  // Associative TLB search; the lowest-numbered valid match wins.
  always_comb begin
    tlb_match       = 1'b0;
    tlb_match_frame = '0;
    for (int i = TlbN - 1; i >= 0; i--) begin
      if (tlb_valid_q[i] && (tlb_page_q[i] == page_q)) begin
        tlb_match       = 1'b1;
        tlb_match_frame = tlb_frame_q[i];
      end
    end
  end

  // The page table read address follows the page under translation, except
  // while scanning for a victim, where it tracks the scan position.
  assign pt_raddr = (state_q == tpt_pkg::ST_SCAN) ? scan_q : page_q;

  always_ff @(posedge clk_i) begin
    pt_rdata_q <= page_frame_mem[pt_raddr];
    if (state_q == tpt_pkg::ST_FILL && fault_q) begin
      page_frame_mem[page_q] <= frame_q;
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      tpt_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) state_d = tpt_pkg::ST_LOOKUP;
      end
      tpt_pkg::ST_LOOKUP: state_d = tpt_pkg::ST_RESOLVE;
      tpt_pkg::ST_RESOLVE: begin
        if (hit_q) begin
          state_d = tpt_pkg::ST_DONE;
        end else if (resident_q[page_q] || free_avail) begin
          state_d = tpt_pkg::ST_FILL;
        end else begin
          state_d = tpt_pkg::ST_SCAN;
        end
      end
      tpt_pkg::ST_SCAN: begin
        if (scan_hit) begin
          state_d = tpt_pkg::ST_EVICT;
        end else if (scan_last) begin
          state_d = tpt_pkg::ST_FILL;
        end
      end
      tpt_pkg::ST_EVICT: state_d = tpt_pkg::ST_FILL;
      tpt_pkg::ST_FILL:  state_d = tpt_pkg::ST_DONE;
      tpt_pkg::ST_DONE: begin
        if (out_free) state_d = tpt_pkg::ST_IDLE;
      end
      default: state_d = tpt_pkg::ST_IDLE;
    endcase
  end

  // Output logic of the sequencer.
  always_comb begin
    s_axis_tready_o = (state_q == tpt_pkg::ST_IDLE);
  end

  assign hit_cnt_nxt    = hit_cnt_q + CntW'(hit_q);
  assign fault_cnt_nxt  = fault_cnt_q + CntW'(fault_q);
  assign access_cnt_nxt = access_cnt_q + CntW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tpt_pkg::ST_IDLE;
      tlb_valid_q  <= '0;
      fill_ptr_q   <= '0;
      resident_q   <= '0;
      next_free_q  <= '0;
      hit_cnt_q    <= '0;
      fault_cnt_q  <= '0;
      access_cnt_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      // A finished item refills the output register once it is empty or its old
      // beat leaves in that cycle; otherwise a taken beat empties it.
      if (state_q == tpt_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        tpt_pkg::ST_EVICT: begin
          // Drop the victim page from residence and from every TLB slot.
          resident_q[ev_page_q] <= 1'b0;
          for (int k = 0; k < TlbN; k++) begin
            if (tlb_valid_q[k] && (tlb_page_q[k] == ev_page_q)) begin
              tlb_valid_q[k] <= 1'b0;
            end
          end
        end
        tpt_pkg::ST_RESOLVE: begin
          if (!hit_q && !resident_q[page_q] && free_avail) begin
            next_free_q <= next_free_q + FreeW'(1);
          end
        end
        tpt_pkg::ST_FILL: begin
          if (fault_q) resident_q[page_q] <= 1'b1;
          tlb_valid_q[fill_ptr_q] <= 1'b1;
          if (fill_ptr_q == IdxW'(TlbN - 1)) begin
            fill_ptr_q <= '0;
          end else begin
            fill_ptr_q <= fill_ptr_q + IdxW'(1);
          end
        end
        tpt_pkg::ST_DONE: begin
          if (out_free) begin
            hit_cnt_q    <= hit_cnt_nxt;
            fault_cnt_q  <= fault_cnt_nxt;
            access_cnt_q <= access_cnt_nxt;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers of the working set, the TLB fields and the result.
  always_ff @(posedge clk_i) begin
    case (state_q)
      tpt_pkg::ST_IDLE: begin
        if (in_fire) begin
          page_q     <= s_axis_tdata_i[15:8];
          offset_q   <= s_axis_tdata_i[7:0];
          fault_q    <= 1'b0;
          ev_valid_q <= 1'b0;
          ev_page_q  <= '0;
          scan_q     <= '0;
        end
      end
      tpt_pkg::ST_LOOKUP: begin
        hit_q   <= tlb_match;
        frame_q <= tlb_match_frame;
      end
      tpt_pkg::ST_RESOLVE: begin
        if (!hit_q) begin
          if (resident_q[page_q]) begin
            frame_q <= pt_rdata_q;
          end else begin
            fault_q <= 1'b1;
            // With no free frame and no resident page, frame zero is used.
            frame_q <= free_avail ? next_free_q[FrW-1:0] : '0;
          end
        end
      end
      tpt_pkg::ST_SCAN: begin
        if (scan_hit) begin
          ev_valid_q <= 1'b1;
          ev_page_q  <= scan_q;
        end else if (!scan_last) begin
          scan_q <= scan_q + PgW'(1);
        end
      end
      tpt_pkg::ST_EVICT: begin
        // The read issued at the scan position returns the victim's frame.
        frame_q <= pt_rdata_q;
      end
      tpt_pkg::ST_FILL: begin
        tlb_page_q[fill_ptr_q]  <= page_q;
        tlb_frame_q[fill_ptr_q] <= frame_q;
      end
      tpt_pkg::ST_DONE: begin
        if (out_free) begin
          out_data_q <= {5'b0, access_cnt_nxt, fault_cnt_nxt, hit_cnt_nxt, ev_page_q,
                         ev_valid_q, fault_q, hit_q, frame_q, offset_q};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the TLB page table translator stream block.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned TlbEntries = tpt_pkg::TlbEntries;
  localparam int unsigned TlbIdxW    = tpt_pkg::TlbIdxW;
  localparam int unsigned PageCount  = tpt_pkg::PageCount;
  localparam int unsigned PageW      = tpt_pkg::PageW;
  localparam int unsigned FrameCount = tpt_pkg::FrameCount;
  localparam int unsigned FrameW     = tpt_pkg::FrameW;
  localparam int unsigned FreeW      = tpt_pkg::FreeW;
  localparam int unsigned CountW     = tpt_pkg::CountW;
  localparam int unsigned InDataW    = tpt_pkg::InDataW;
  localparam int unsigned OutDataW   = tpt_pkg::OutDataW;

  // One translation result, packed in the same bit order as the result beat.
  typedef struct packed {
    logic [CountW-1:0] access_total;
    logic [CountW-1:0] fault_total;
    logic [CountW-1:0] hit_total;
    logic [PageW-1:0]  evicted_page;
    logic              evicted_valid;
    logic              page_fault;
    logic              tlb_hit;
    logic [15:0]       phys_addr;
  } xlat_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  tlb_page_table_translator dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  // Shadow copy of the translator state.
  logic                 tlb_valid [TlbEntries];
  logic [PageW-1:0]     tlb_page  [TlbEntries];
  logic [FrameW-1:0]    tlb_frame [TlbEntries];
  logic [TlbIdxW-1:0]   tlb_fill_ptr;
  logic                 resident  [PageCount];
  logic [FrameW-1:0]    frame_of  [PageCount];
  logic [FreeW-1:0]     free_frame;
  logic [CountW-1:0]    hit_count;
  logic [CountW-1:0]    fault_count;
  logic [CountW-1:0]    access_count;

  logic [InDataW-1:0] pending_addrs[$];
  xlat_t              predicted_xlats[$];
  int                 addrs_accepted = 0;
  int                 results_seen = 0;
  int                 failures = 0;
  int                 stall_left = 0;
  logic               held_off = 1'b0;

  function automatic xlat_t predict_xlat(input logic [InDataW-1:0] laddr);
    logic [PageW-1:0]  page;
    logic [FrameW-1:0] frame;
    logic [PageW-1:0]  victim;
    logic              hit;
    logic              fault;
    logic              victim_found;
    xlat_t             r;
    int                i;
    page = laddr[15:8];
    frame = '0;
    victim = '0;
    hit = 1'b0;
    fault = 1'b0;
    victim_found = 1'b0;
    access_count = access_count + CountW'(1);
    // Lowest-numbered valid match wins.
    for (i = 0; i < TlbEntries; i++) begin
      if (!hit && tlb_valid[i] && tlb_page[i] == page) begin
        hit = 1'b1;
        frame = tlb_frame[i];
      end
    end
    if (hit) begin
      hit_count = hit_count + CountW'(1);
    end else begin
      if (resident[page]) begin
        frame = frame_of[page];
      end else begin
        fault = 1'b1;
        fault_count = fault_count + CountW'(1);
        if (free_frame < FrameCount) begin
          frame = free_frame[FrameW-1:0];
          free_frame = free_frame + FreeW'(1);
        end else begin
          // No frame left: the lowest resident page gives up its frame.
          for (i = 0; i < PageCount; i++) begin
            if (!victim_found && resident[i]) begin
              victim_found = 1'b1;
              victim = i[PageW-1:0];
            end
          end
          if (victim_found) begin
            for (i = 0; i < TlbEntries; i++) begin
              if (tlb_valid[i] && tlb_page[i] == victim) tlb_valid[i] = 1'b0;
            end
            frame = frame_of[victim];
            resident[victim] = 1'b0;
          end
        end
        resident[page] = 1'b1;
        frame_of[page] = frame;
      end
      tlb_valid[tlb_fill_ptr] = 1'b1;
      tlb_page[tlb_fill_ptr] = page;
      tlb_frame[tlb_fill_ptr] = frame;
      tlb_fill_ptr = tlb_fill_ptr + TlbIdxW'(1);
    end
    r.phys_addr = {frame, laddr[7:0]};
    r.tlb_hit = hit;
    r.page_fault = fault;
    r.evicted_valid = victim_found;
    r.evicted_page = victim;
    r.hit_total = hit_count;
    r.fault_total = fault_count;
    r.access_total = access_count;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [CountW-1:0] want,
                             input logic [CountW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      failures++;
    end
  endtask

  // Sender: feeds addresses from the pending queue and predicts on acceptance.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= '0;
    end else begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (s_axis_tvalid) begin
          predicted_xlats.push_back(predict_xlat(s_axis_tdata));
          addrs_accepted++;
        end
        if (pending_addrs.size() != 0 &&
            ((addrs_accepted >= 300 && addrs_accepted < 450) ||
             $urandom_range(0, 99) >= 33)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= pending_addrs.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result beat and throttles ready.
  always @(posedge clk_i or negedge rst_ni) begin
    xlat_t want;
    xlat_t got;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left <= 0;
      held_off <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[$bits(xlat_t)-1:0];
        if (predicted_xlats.size() == 0) begin
          $display("%0t: unexpected result beat 0x%0h", $time, m_axis_tdata);
          failures++;
        end else begin
          want = predicted_xlats.pop_front();
          check_field("phys_addr", CountW'(want.phys_addr), CountW'(got.phys_addr));
          check_field("tlb_hit", CountW'(want.tlb_hit), CountW'(got.tlb_hit));
          check_field("page_fault", CountW'(want.page_fault), CountW'(got.page_fault));
          check_field("evicted_valid", CountW'(want.evicted_valid),
                      CountW'(got.evicted_valid));
          check_field("evicted_page", CountW'(want.evicted_page),
                      CountW'(got.evicted_page));
          check_field("hit_total", want.hit_total, got.hit_total);
          check_field("fault_total", want.fault_total, got.fault_total);
          check_field("access_total", want.access_total, got.access_total);
        end
        results_seen++;
      end
      // One long hold-off lets the block back up into its input.
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        m_axis_tready <= 1'b0;
      end else if (!held_off && results_seen >= 100) begin
        stall_left <= 300;
        held_off <= 1'b1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= (results_seen >= 500 && results_seen < 650) ||
                         ($urandom_range(0, 99) >= 33);
      end
    end
  end

  // Random address that favors recently touched pages to produce TLB hits.
  function automatic logic [InDataW-1:0] mixed_address(ref logic [PageW-1:0] recent[$]);
    logic [PageW-1:0] page;
    if (recent.size() != 0 && $urandom_range(0, 99) < 40) begin
      page = recent[$urandom_range(0, recent.size() - 1)];
    end else begin
      page = PageW'($urandom_range(0, PageCount - 1));
      recent.push_back(page);
      if (recent.size() > 8) void'(recent.pop_front());
    end
    return {page, 8'($urandom_range(0, 255))};
  endfunction

  initial begin
    logic [PageW-1:0] recent[$];
    logic [PageW-1:0] sweep[PageCount];
    logic [PageW-1:0] tmp;
    int               i;
    int               j;
    for (i = 0; i < TlbEntries; i++) tlb_valid[i] = 1'b0;
    for (i = 0; i < PageCount; i++) resident[i] = 1'b0;
    tlb_fill_ptr = '0;
    free_frame = '0;
    hit_count = '0;
    fault_count = '0;
    access_count = '0;

    // Directed part: offset and page extremes, faults, TLB hits, and a
    // resident page that has been pushed out of the TLB.
    pending_addrs = '{16'h0000, 16'h00FF, 16'hFFFF, 16'hFF00, 16'h1234, 16'h1299,
                      16'hAA55, 16'h55AA, 16'h8001, 16'h7FFE};
    for (i = 0; i < 14; i++) pending_addrs.push_back({8'(8'h20 + i), 8'(i * 17)});
    pending_addrs.push_back(16'h0042);

    // Random part: a mix, then a sweep of every page in shuffled order so that
    // the free frames run out, then more of the mix.
    for (i = 0; i < 400; i++) pending_addrs.push_back(mixed_address(recent));
    for (i = 0; i < PageCount; i++) sweep[i] = i[PageW-1:0];
    for (i = PageCount - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = sweep[i];
      sweep[i] = sweep[j];
      sweep[j] = tmp;
    end
    for (i = 0; i < PageCount; i++) begin
      pending_addrs.push_back({sweep[i], 8'($urandom_range(0, 255))});
    end
    for (i = 0; i < 250; i++) pending_addrs.push_back(mixed_address(recent));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i); while (pending_addrs.size() != 0 || s_axis_tvalid);
    do @(posedge clk_i); while (predicted_xlats.size() != 0);
    repeat (300) @(posedge clk_i);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
